@@ sv/tiled_background_pixel_fetch_unit_defines.svh @@
// Assertion macros for the background pixel fetch unit
`ifndef TILED_BACKGROUND_PIXEL_FETCH_UNIT_DEFINES_SVH
`define TILED_BACKGROUND_PIXEL_FETCH_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TBF_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: label");
`define TBF_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("%m: label");
`else
`define TBF_ASSERT_IMPL(label, clk, rst, prop)
`define TBF_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

@@ sv/tbf_pkg.sv @@
`default_nettype none
package tbf_pkg;

   localparam logic [1:0] CMD_RENDER = 2'd0;
   localparam logic [1:0] CMD_WR_VRAM = 2'd1;
   localparam logic [1:0] CMD_WR_PAL = 2'd2;

   localparam logic [2:0] REG_BG_CONTROL = 3'd0;
   localparam logic [2:0] REG_H_SCROLL = 3'd1;
   localparam logic [2:0] REG_V_SCROLL = 3'd2;
   localparam logic [2:0] REG_MOSAIC_H = 3'd3;
   localparam logic [2:0] REG_MOSAIC_V = 3'd4;

   typedef struct packed {
      logic [1:0] command;
      logic [15:0] mem_address;
      logic [15:0] write_value;
      logic [7:0] screen_x;
      logic [7:0] screen_line;
   } req_type;

   typedef struct packed {
      logic [15:0] pixel_color;
      logic opaque;
   } rsp_type;

   // ceil(4096 / (m+1)); (v * recip) >> 12 gives v / (m+1) exactly for v under 256
   function automatic logic [12:0] mosaic_recip(input logic [3:0] m);
      logic [12:0] r;
      case (m)
         4'd0: r = 13'd4096;
         4'd1: r = 13'd2048;
         4'd2: r = 13'd1366;
         4'd3: r = 13'd1024;
         4'd4: r = 13'd820;
         4'd5: r = 13'd683;
         4'd6: r = 13'd586;
         4'd7: r = 13'd512;
         4'd8: r = 13'd456;
         4'd9: r = 13'd410;
         4'd10: r = 13'd373;
         4'd11: r = 13'd342;
         4'd12: r = 13'd316;
         4'd13: r = 13'd293;
         4'd14: r = 13'd274;
         default: r = 13'd256;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

@@ sv/tiled_background_pixel_fetch_unit.sv @@
// Renders pass from start to rsp_valid through these stages, one item per cycle, back to back.
// Stages: mosaic quotient, mosaic snap, scroll/map address, map read, tile address,
// texel read, palette read, output register. busy is always low; the receiver cannot stall.
// Writes give no result; they trail the render stages so each render sees earlier writes only.
// Synchronous reset clears the control registers and pipeline valids; memories are not cleared.
`default_nettype none
`include "tiled_background_pixel_fetch_unit_defines.svh"
module tiled_background_pixel_fetch_unit #(
   parameter int VRAM_HALFWORDS = 49152
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire tbf_pkg::req_type req_data,
   output logic rsp_valid,
   output tbf_pkg::rsp_type rsp_data,
   input wire logic csr_write,
   input wire logic [2:0] csr_index,
   input wire logic [15:0] csr_data
);
   localparam int Aw = (VRAM_HALFWORDS > 32768) ? 17 : 16;
   localparam int Ix = $clog2(VRAM_HALFWORDS);

   logic [15:0] bg_ff;
   logic [8:0] hs_ff, vs_ff;
   logic [3:0] mh_ff, mv_ff;
   logic [15:0] vram [VRAM_HALFWORDS];
   logic [15:0] pal [256];
   logic acc, rnd;

   assign busy = 1'b0;
   assign acc = start && !busy;
   assign rnd = acc && req_data.command == tbf_pkg::CMD_RENDER;

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_ff <= '0; hs_ff <= '0; vs_ff <= '0; mh_ff <= '0; mv_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            tbf_pkg::REG_BG_CONTROL: bg_ff <= csr_data;
            tbf_pkg::REG_H_SCROLL: hs_ff <= csr_data[8:0];
            tbf_pkg::REG_V_SCROLL: vs_ff <= csr_data[8:0];
            tbf_pkg::REG_MOSAIC_H: mh_ff <= csr_data[3:0];
            tbf_pkg::REG_MOSAIC_V: mv_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   logic a_v;
   logic [Aw-1:0] a_addr;
   logic [2:0] a_tx, a_ty;
   tbf_addr_stage #(.MapAw(Aw)) u_addr (
      .clock, .reset, .in_valid(rnd), .in_x(req_data.screen_x), .in_y(req_data.screen_line),
      .bg_control(bg_ff), .h_scroll(hs_ff), .v_scroll(vs_ff),
      .mosaic_h(mh_ff), .mosaic_v(mv_ff),
      .out_valid(a_v), .map_addr(a_addr), .out_tx(a_tx), .out_ty(a_ty));

   // write transfers travel down a delay line: video memory is written at the same edge as
   // the map read of the next render, the palette before that render's palette read
   logic wr_vram, wr_pal;
   logic [3:0] wv_ff;
   logic [4:0] wp_ff;
   logic [15:0] wa_ff [5];
   logic [15:0] wd_ff [5];
   assign wr_vram = acc && req_data.command == tbf_pkg::CMD_WR_VRAM
                    && {1'b0, req_data.mem_address} < 17'(VRAM_HALFWORDS);
   assign wr_pal = acc && req_data.command == tbf_pkg::CMD_WR_PAL
                   && req_data.mem_address < 16'd256;

   always_ff @(posedge clock) begin
      wa_ff[0] <= req_data.mem_address;
      wd_ff[0] <= req_data.write_value;
      for (int i = 1; i < 5; i++) begin
         wa_ff[i] <= wa_ff[i-1];
         wd_ff[i] <= wd_ff[i-1];
      end
      if (reset) begin
         wv_ff <= '0;
         wp_ff <= '0;
      end else begin
         wv_ff <= {wv_ff[2:0], wr_vram};
         wp_ff <= {wp_ff[3:0], wr_pal};
      end
   end

   // map read; a write landing at the same edge is forwarded
   logic m_v_ff, m_oob_ff, m_fwd_ff;
   logic [15:0] m_ent_ff, m_wd_ff;
   logic [2:0] m_tx_ff, m_ty_ff;

   always_ff @(posedge clock) begin
      if (wv_ff[3]) vram[wa_ff[3][Ix-1:0]] <= wd_ff[3];
      m_ent_ff <= vram[a_addr[Ix-1:0]];
      m_fwd_ff <= wv_ff[3] && Aw'(wa_ff[3]) == a_addr;
      m_wd_ff <= wd_ff[3];
      m_oob_ff <= 17'(a_addr) >= 17'(VRAM_HALFWORDS);
      m_tx_ff <= a_tx;
      m_ty_ff <= a_ty;
      if (reset) m_v_ff <= 1'b0;
      else m_v_ff <= a_v;
   end

   // tile byte address
   logic [15:0] ent;
   logic [2:0] tx, ty;
   logic [17:0] baddr;
   logic t_v_ff, t_hi_ff, t_eight_ff;
   logic [17:0] t_baddr_ff;
   logic [3:0] t_bank_ff;
   always_comb begin
      ent = m_oob_ff ? 16'd0 : (m_fwd_ff ? m_wd_ff : m_ent_ff);
      tx = ent[10] ? 3'd7 - m_tx_ff : m_tx_ff;
      ty = ent[11] ? 3'd7 - m_ty_ff : m_ty_ff;
      if (bg_ff[7])
         baddr = {2'd0, bg_ff[3:2], 14'd0} + {2'd0, ent[9:0], ty, tx};
      else
         baddr = {2'd0, bg_ff[3:2], 14'd0} + {3'd0, ent[9:0], ty, tx[2:1]};
   end
   always_ff @(posedge clock) begin
      t_baddr_ff <= baddr;
      t_hi_ff <= tx[0];
      t_bank_ff <= ent[15:12];
      t_eight_ff <= bg_ff[7];
      if (reset) t_v_ff <= 1'b0;
      else t_v_ff <= m_v_ff;
   end

   // texel read
   logic x_v_ff, x_oob_ff, x_hi_ff, x_b_ff, x_eight_ff;
   logic [15:0] x_half_ff;
   logic [3:0] x_bank_ff;
   always_ff @(posedge clock) begin
      x_half_ff <= vram[t_baddr_ff[Ix:1]];
      x_oob_ff <= t_baddr_ff[17:1] >= 17'(VRAM_HALFWORDS);
      x_b_ff <= t_baddr_ff[0];
      x_hi_ff <= t_hi_ff;
      x_bank_ff <= t_bank_ff;
      x_eight_ff <= t_eight_ff;
      if (reset) x_v_ff <= 1'b0;
      else x_v_ff <= t_v_ff;
   end

   logic [7:0] byt, texel, pidx;
   always_comb begin
      byt = x_oob_ff ? 8'd0 : (x_b_ff ? x_half_ff[15:8] : x_half_ff[7:0]);
      if (x_eight_ff) begin
         texel = byt;
         pidx = byt;
      end else begin
         texel = {4'd0, x_hi_ff ? byt[7:4] : byt[3:0]};
         pidx = {x_bank_ff, texel[3:0]};
      end
   end

   // palette read
   logic p_v_ff, p_op_ff;
   logic [15:0] p_col_ff;
   always_ff @(posedge clock) begin
      if (wp_ff[4]) pal[wa_ff[4][7:0]] <= wd_ff[4];
      p_col_ff <= pal[pidx];
      p_op_ff <= texel != 8'd0;
      if (reset) p_v_ff <= 1'b0;
      else p_v_ff <= x_v_ff;
   end

   logic o_v_ff;
   tbf_pkg::rsp_type o_ff;
   always_ff @(posedge clock) begin
      o_ff.opaque <= p_op_ff;
      o_ff.pixel_color <= p_op_ff ? (p_col_ff | 16'h8000) : 16'd0;
      if (reset) o_v_ff <= 1'b0;
      else o_v_ff <= p_v_ff;
   end

   assign rsp_valid = o_v_ff;
   assign rsp_data = o_ff;

   `TBF_ASSERT_IMPL(a_busy_low, clock, reset, busy == 1'b0)
   `TBF_ASSERT_IMPL(a_latency, clock, reset, rnd |-> ##8 rsp_valid)
   `TBF_ASSERT_NEVER(a_clear, clock, reset, rsp_valid && !rsp_data.opaque && |rsp_data.pixel_color)
   `TBF_ASSERT_IMPL(a_no_spurious, clock, reset, rsp_valid |-> $past(rnd, 8))
endmodule
`default_nettype wire

@@ sv/tbf_addr_stage.sv @@
`default_nettype none
// Mosaic, scroll and screen block selection; registers the map read address
module tbf_addr_stage #(
   parameter int MapAw = 15
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   input wire logic [7:0] in_x,
   input wire logic [7:0] in_y,
   input wire logic [15:0] bg_control,
   input wire logic [8:0] h_scroll,
   input wire logic [8:0] v_scroll,
   input wire logic [3:0] mosaic_h,
   input wire logic [3:0] mosaic_v,
   output logic out_valid,
   output logic [MapAw-1:0] map_addr,
   output logic [2:0] out_tx,
   output logic [2:0] out_ty
);
   logic [3:0] mhe, mve;
   logic [4:0] bx, by;
   logic [12:0] rx, ry;
   logic [19:0] px, py;
   logic [7:0] qx_in, qy_in, qx_ff, qy_ff;
   logic [12:0] sx, sy;
   logic [7:0] mx_ff, my_ff, mx_in, my_in;
   logic v1_ff, v2_ff, v3_ff;
   logic [8:0] xx, yy;
   logic [MapAw-1:0] base, addr_ff;
   logic [2:0] tx_ff, ty_ff;
   logic wide, tall;

   // first stage: block index by reciprocal multiply; mosaic off acts as a block of one
   always_comb begin
      mhe = bg_control[6] ? mosaic_h : 4'd0;
      mve = bg_control[6] ? mosaic_v : 4'd0;
      bx = {1'b0, mhe} + 5'd1;
      by = {1'b0, mve} + 5'd1;
      rx = tbf_pkg::mosaic_recip(mhe);
      ry = tbf_pkg::mosaic_recip(mve);
      px = 20'(in_x) * 20'(rx);
      py = 20'(in_y) * 20'(ry);
      qx_in = 8'(px >> 12);
      qy_in = 8'(py >> 12);
   end

   always_ff @(posedge clock) begin
      qx_ff <= qx_in;
      qy_ff <= qy_in;
      mx_ff <= mx_in;
      my_ff <= my_in;
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // second stage: back to the start of the block
   always_comb begin
      sx = 13'(qx_ff) * 13'(bx);
      sy = 13'(qy_ff) * 13'(by);
      mx_in = 8'(sx);
      my_in = 8'(sy);
   end

   always_comb begin
      wide = bg_control[14];
      tall = bg_control[15];
      xx = {1'b0, mx_ff} + h_scroll;
      yy = {1'b0, my_ff} + v_scroll;
      base = MapAw'({bg_control[12:8], 10'd0});
      if (xx[8] && wide) base = base + MapAw'(16'h400);
      if (yy[8] && tall) base = base + (wide ? MapAw'(16'h800) : MapAw'(16'h400));
   end

   always_ff @(posedge clock) begin
      addr_ff <= base + MapAw'({yy[7:3], xx[7:3]});
      tx_ff <= xx[2:0];
      ty_ff <= yy[2:0];
   end

   assign out_valid = v3_ff;
   assign map_addr = addr_ff;
   assign out_tx = tx_ff;
   assign out_ty = ty_ff;
endmodule
`default_nettype wire
